FILE: sv/trial_division_prime_test_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define TDPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: sv/tdpt_pkg.sv
package tdpt_pkg;

    // Width of the candidate and echo fields on the ports.
    localparam int DATA_WIDTH = 32;

    // Defaults of the top-level parameters.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam longint unsigned TABLE_DEPTH_DEF = 64'd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_step;
        logic sv_init;
        logic p_next;
        logic mark_init;
        logic mark_step;
        logic rd_sel_p;
        logic load_in;
        logic j_inc;
        logic div_start;
        logic div_step;
        logic res_load;
        logic res_bit;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic sq_done;
        logic m_done;
        logic flag;
        logic j_beyond;
        logic v_small;
        logic div_last;
        logic bound_over;
        logic rem_zero;
        logic slot_free;
    } status_t;

endpackage

FILE: sv/tdpt_if.sv
// Request channel: one candidate per word.
interface tdpt_req_if;
    logic                           valid;
    logic                           ready;
    logic [tdpt_pkg::DATA_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// Response channel: the tested value and its verdict per word.
interface tdpt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tdpt_pkg::DATA_WIDTH-1:0] tested_value;
    logic                           is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

FILE: sv/tdpt_ctrl.sv
module tdpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tdpt_pkg::status_t sts,
    output tdpt_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_FILL,
        ST_SV_LOOK,
        ST_SV_TEST,
        ST_SV_MARK,
        ST_IDLE,
        ST_T_LOOK,
        ST_T_TEST,
        ST_T_DIV,
        ST_T_CHECK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.sv_init = 1'b1;
                    state_next  = ST_SV_LOOK;
                end
            end
            ST_SV_LOOK:
            begin
                cmd.rd_sel_p = 1'b1;
                state_next   = ST_SV_TEST;
            end
            ST_SV_TEST:
            begin
                priority if (sts.sq_done)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
                else if (sts.flag)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = ST_SV_MARK;
                end
                else
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_SV_LOOK;
                end
            end
            ST_SV_MARK:
            begin
                if (sts.m_done)
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_SV_LOOK;
                end
                else
                begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load_in   = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = ST_T_LOOK;
                end
            end
            ST_T_LOOK:
            begin
                if (sts.v_small)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_bit  = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_T_TEST;
                end
            end
            ST_T_TEST:
            begin
                if (sts.j_beyond || sts.flag)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_T_DIV;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_T_LOOK;
                end
            end
            ST_T_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_T_CHECK;
                end
            end
            ST_T_CHECK:
            begin
                priority if (sts.bound_over)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_bit  = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (sts.rem_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_bit  = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_T_LOOK;
                end
            end
            ST_DONE:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_out  = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_FILL;
                in_ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

FILE: sv/tdpt_datapath.sv
module tdpt_datapath #(
    parameter int              VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
    parameter longint unsigned TABLE_DEPTH = tdpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tdpt_pkg::cmd_t                  cmd,
    output tdpt_pkg::status_t               sts,
    input  logic [tdpt_pkg::DATA_WIDTH-1:0] candidate,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tdpt_pkg::DATA_WIDTH-1:0] tested_value,
    output logic                            is_prime
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = tdpt_pkg::DATA_WIDTH;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(VW);

    // Flag table, one bit per small integer.
    logic flag_mem [0:TABLE_DEPTH-1];

    logic [AW-1:0] k_reg;
    logic [AW:0]   p_reg;
    logic [AW+1:0] sq_reg;
    logic [AW:0]   m_reg;
    logic [VW-1:0] v_reg;
    logic [VW-1:0] j_reg;
    logic [VW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          res_reg;
    logic          flag_q_reg;
    logic          out_valid_reg;
    logic [DW-1:0] out_value_reg;
    logic          out_prime_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          wr_data;
    logic [VW:0]   trial;
    logic          trial_ge;
    logic [VW:0]   trial_diff;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] quo_next;

    assign rd_addr = cmd.rd_sel_p ? AW'(p_reg) : AW'(j_reg);
    assign wr_en   = cmd.fill_step || cmd.mark_step;
    assign wr_addr = cmd.fill_step ? k_reg : AW'(m_reg);
    assign wr_data = cmd.fill_step;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= wr_data;
        end
        flag_q_reg <= flag_mem[rd_addr];
    end

    // One restoring division step: one quotient bit per cycle.
    assign trial      = {rem_reg, quo_reg[VW-1]};
    assign trial_ge   = trial >= {1'b0, j_reg};
    assign trial_diff = trial - {1'b0, j_reg};
    assign rem_next   = trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
    assign quo_next   = {quo_reg[VW-2:0], trial_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill_step)
            begin
                k_reg <= k_reg + AW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sv_init)
        begin
            p_reg  <= (AW+1)'(2);
            sq_reg <= (AW+2)'(4);
        end
        else if (cmd.p_next)
        begin
            p_reg  <= p_reg + (AW+1)'(1);
            sq_reg <= sq_reg + (AW+2)'({p_reg, 1'b1});
        end
        if (cmd.mark_init)
        begin
            m_reg <= (AW+1)'(sq_reg);
        end
        else if (cmd.mark_step)
        begin
            m_reg <= m_reg + p_reg;
        end
        if (cmd.load_in)
        begin
            v_reg <= VW'(candidate);
            j_reg <= VW'(2);
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + VW'(1);
        end
        if (cmd.div_start)
        begin
            quo_reg <= v_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.res_load)
        begin
            res_reg <= cmd.res_bit;
        end
        if (cmd.load_out)
        begin
            out_value_reg <= DW'(v_reg);
            out_prime_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.fill_last  = k_reg == AW'(TABLE_DEPTH - 64'd1);
        sts.sq_done    = sq_reg >= (AW+2)'(TABLE_DEPTH);
        sts.m_done     = m_reg >= (AW+1)'(TABLE_DEPTH);
        sts.flag       = flag_q_reg;
        sts.j_beyond   = 64'(j_reg) >= 64'(TABLE_DEPTH);
        sts.v_small    = v_reg < VW'(2);
        sts.div_last   = cnt_reg == CW'(VW - 1);
        sts.bound_over = j_reg > quo_reg;
        sts.rem_zero   = rem_reg == VW'(0);
        sts.slot_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = out_value_reg;
    assign is_prime     = out_prime_reg;

endmodule

FILE: sv/trial_division_prime_test_unit.sv
// Channel | Direction | Word fields
// --------+-----------+------------------------------------------
// req     | in        | candidate[31:0]
// rsp     | out       | tested_value[31:0], is_prime
//
// After reset every flag-table entry is written to one and the composites are sieved
// out; req.ready stays low until the sieve is done.
// For a candidate of two or more, divisors are stepped from two to the first factor or
// the first tried one past the square root; those flagged prime in the table, or past
// its end, go through the one-bit-per-cycle divider. Zero and one are reported not
// prime without a division. A held result word stalls only the load of the next one.

module trial_division_prime_test_unit #(
    parameter int              VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
    parameter longint unsigned TABLE_DEPTH = tdpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tdpt_req_if.sink   req,
    tdpt_rsp_if.source rsp
);

    // The controller steps through the startup fill, the sieve, and then for each
    // candidate the divisor loop; the datapath holds the flag table, the counters,
    // the iterative divider and the output register.
    tdpt_pkg::cmd_t    cmd;
    tdpt_pkg::status_t sts;
    logic              in_ready;

    tdpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .candidate    (req.candidate),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .tested_value (rsp.tested_value),
        .is_prime     (rsp.is_prime)
    );

    // The request side is taken only from the idle state.
    assign req.ready = in_ready;

endmodule

FILE: sv/tdpt_checker.sv
`include "trial_division_prime_test_unit_macros.svh"

module tdpt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [tdpt_pkg::DATA_WIDTH-1:0] tested_value,
    input logic                            is_prime
);

    // A stalled result word keeps its valid flag and its contents.
    `TDPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `TDPT_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(tested_value) && $stable(is_prime))

    // Zero and one are never reported prime.
    `TDPT_ASSERT_IMP(a_small_not_prime, clk, rst_n, out_valid && (tested_value < 2), !is_prime)

    // Only one candidate is in work at a time.
    `TDPT_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .tested_value (rsp.tested_value),
    .is_prime     (rsp.is_prime)
);
